/* rtl/leb_pkg.sv */
package leb_pkg;

  localparam int CHAR_W = 8;
  localparam int LEB_CAPACITY = 63;

  // printable range accepted by type
  localparam logic [CHAR_W-1:0] CHAR_LOW = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HIGH = 8'd126;

  typedef enum logic [2:0] {
    CMD_TYPE  = 3'd0,
    CMD_ERASE = 3'd1,
    CMD_HOME  = 3'd2,
    CMD_END   = 3'd3,
    CMD_LEFT  = 3'd4,
    CMD_RIGHT = 3'd5,
    CMD_PRINT = 3'd6
  } cmd_t;

endpackage

/* rtl/line_edit_buffer.sv */
// line edit buffer: one line of text with a cursor, one command per input transfer
//
// input channel (in_valid / in_stall): command, key_char, cursor_mark.
// output channel (out_valid / out_stall): success, has_char, out_char, last.
// a command is taken only while the block is idle; its results leave through an
// output register, so the next command is taken while the last result still waits.
//
// steps per command, from the input transfer to the result register load:
//   home, end, left, right, rejected type or erase, empty print: straight to the result
//   type: a shift of the tail up unless the cursor is at the end, then the key write
//   erase: a shift of the tail down, with nothing to move at the end of the line
//   print: a mark, a read and a character state per stored character, the separator
//   adds no state; each result also waits for the output register
// the steps come from the single text memory: one read and one write a cycle,
// read data registered, so a shift moves one character per cycle and print
// reads one character at a time.
//
// reset empties the line and puts the cursor at zero; the memory is not cleared.
// a stall on the output freezes the result register; a command waits only where it loads
module line_edit_buffer
  import leb_pkg::*;
#(
  parameter int CAPACITY = LEB_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        command,
  input  logic [CHAR_W-1:0] key_char,
  input  logic [CHAR_W-1:0] cursor_mark,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              success,
  output logic              has_char,
  output logic [CHAR_W-1:0] out_char,
  output logic              last
);

  // counters hold 0..CAPACITY, memory addresses 0..CAPACITY-1
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHIFT = 7'b0000010,
    S_KEY   = 7'b0000100,
    S_RESP  = 7'b0001000,
    S_PMARK = 7'b0010000,
    S_PREAD = 7'b0100000,
    S_PCHAR = 7'b1000000
  } state_t;

  state_t state;

  logic [LW-1:0] len;       // characters stored
  logic [LW-1:0] cur;       // cursor position
  logic [LW-1:0] ptr;       // shift read address, or print position
  logic [LW-1:0] stop;      // last address the shift reads
  logic [LW-1:0] last_ra;   // address read in the previous shift cycle
  logic          rd_more;   // shift still has reads to issue
  logic          pend;      // read data waiting to be written back
  logic          is_ins;    // shift direction: up for type, down for erase
  logic [CHAR_W-1:0] key_reg;
  logic [CHAR_W-1:0] mark_reg;
  logic          res_ok;

  // memory port
  logic              ram_we;
  logic              ram_re;
  logic [LW-1:0]     wa_full;
  logic [LW-1:0]     ra_full;
  logic [CHAR_W-1:0] ram_wdata;
  logic [CHAR_W-1:0] ram_rdata;

  logic out_free;
  logic key_ok;
  logic mark_here;

  leb_text_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wa_full[AW-1:0]),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ra_full[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign key_ok    = (key_char >= CHAR_LOW) && (key_char <= CHAR_HIGH);
  assign mark_here = (ptr == cur) && (mark_reg != '0);

  // memory control: shift reads one address while writing the one read before
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    wa_full   = cur;
    ra_full   = ptr;
    ram_wdata = ram_rdata;
    case (state)
      S_SHIFT: begin
        ram_re  = rd_more;
        ram_we  = pend;
        wa_full = is_ins ? (last_ra + LW'(1)) : (last_ra - LW'(1));
      end
      S_KEY: begin
        ram_we    = 1'b1;
        ram_wdata = key_reg;
      end
      S_PREAD: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      cur       <= '0;
      rd_more   <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result register empties on a transfer, a load below overrides
      if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_reg  <= key_char;
            mark_reg <= cursor_mark;
            res_ok   <= 1'b1;
            state    <= S_RESP;
            case (command)
              CMD_TYPE: begin
                if (!key_ok || (len == LW'(CAPACITY))) begin
                  res_ok <= 1'b0;
                end else if (cur == len) begin
                  state <= S_KEY;
                end else begin
                  // move cursor..len-1 up by one, from the top down
                  state   <= S_SHIFT;
                  is_ins  <= 1'b1;
                  ptr     <= len - LW'(1);
                  stop    <= cur;
                  rd_more <= 1'b1;
                  pend    <= 1'b0;
                end
              end
              CMD_ERASE: begin
                if (cur == '0) begin
                  res_ok <= 1'b0;
                end else begin
                  // move cursor..len-1 down by one; nothing to move at the end
                  state   <= S_SHIFT;
                  is_ins  <= 1'b0;
                  ptr     <= cur;
                  stop    <= len - LW'(1);
                  rd_more <= (cur != len);
                  pend    <= 1'b0;
                end
              end
              CMD_HOME: begin
                cur <= '0;
              end
              CMD_END: begin
                cur <= len;
              end
              CMD_LEFT: begin
                if (cur != '0) begin
                  cur <= cur - LW'(1);
                end
              end
              CMD_RIGHT: begin
                if (cur != len) begin
                  cur <= cur + LW'(1);
                end
              end
              CMD_PRINT: begin
                // an empty print gives the same single result as a plain command
                if ((len != '0) || (cursor_mark != '0)) begin
                  state <= S_PMARK;
                  ptr   <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SHIFT: begin
          pend <= rd_more;
          if (rd_more) begin
            last_ra <= ptr;
            if (ptr == stop) begin
              rd_more <= 1'b0;
            end else begin
              ptr <= is_ins ? (ptr - LW'(1)) : (ptr + LW'(1));
            end
          end
          if (!rd_more && !pend) begin
            if (is_ins) begin
              state <= S_KEY;
            end else begin
              len   <= len - LW'(1);
              cur   <= cur - LW'(1);
              state <= S_RESP;
            end
          end
        end

        S_KEY: begin
          len   <= len + LW'(1);
          cur   <= cur + LW'(1);
          state <= S_RESP;
        end

        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            success   <= res_ok;
            has_char  <= 1'b0;
            out_char  <= '0;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end

        S_PMARK: begin
          if (mark_here) begin
            if (out_free) begin
              out_valid <= 1'b1;
              success   <= 1'b1;
              has_char  <= 1'b1;
              out_char  <= mark_reg;
              last      <= (ptr == len);
              state     <= (ptr == len) ? S_IDLE : S_PREAD;
            end
          end else begin
            state <= (ptr == len) ? S_IDLE : S_PREAD;
          end
        end

        S_PREAD: begin
          state <= S_PCHAR;
        end

        S_PCHAR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            success   <= 1'b1;
            has_char  <= 1'b1;
            out_char  <= ram_rdata;
            // last character is final unless a separator follows at the end
            last      <= ((ptr + LW'(1)) == len) && !((cur == len) && (mark_reg != '0));
            ptr       <= ptr + LW'(1);
            state     <= S_PMARK;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // cursor stays inside the line
  a_cur_in_line: assert property (@(posedge clk) disable iff (rst) cur <= len)
    else $error("cursor beyond end of line");

  // line never grows past the memory
  a_len_cap: assert property (@(posedge clk) disable iff (rst) len <= LW'(CAPACITY))
    else $error("length beyond capacity");

  // the shift never reads the entry it is writing in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (wa_full != ra_full))
    else $error("read and write at the same address");

  // every accepted command moves the block out of idle in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("command accepted without work");

  // length moves by at most one per cycle
  a_len_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (len != $past(len))) |->
      ((len == $past(len) + LW'(1)) || (len == $past(len) - LW'(1))))
    else $error("length jumped");

endmodule

/* rtl/leb_text_ram.sv */
module leb_text_ram
  import leb_pkg::*;
#(
  parameter int DEPTH = LEB_CAPACITY,
  parameter int AW = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sim/line_edit_buffer_test.sv */
`timescale 1ns / 1ps

module line_edit_buffer_test;
  import leb_pkg::*;

  // code 7 has no member in cmd_t, the block treats it as a no-op
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // no-transfer cycles before the run is declared hung; a full-line shift or a
  // long print with output stalls stays far below this
  localparam int HANG_LIMIT = 4000;
  // cycles left for stray results after the last expected one
  localparam int DRAIN_CYCLES = 70;

  // one result transfer as it leaves the block
  typedef struct packed {
    logic       success;
    logic       has_char;
    logic [7:0] out_char;
    logic       last;
  } edit_out_t;

  // one row of the directed table; typed rows carry their own single result
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] key;
    logic [7:0] mark;
    logic       typed;
    logic       ok;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{CMD_PRINT,  8'h00, 8'h00, 1'b1, 1'b1}, // empty print on an empty line
    '{CMD_ERASE,  8'hff, 8'hff, 1'b1, 1'b0}, // erase with the cursor at the start
    '{CMD_LEFT,   8'h00, 8'h00, 1'b1, 1'b1}, // left at the start, no move
    '{CMD_RIGHT,  8'hff, 8'h00, 1'b1, 1'b1}, // right at the end, no move
    '{CMD_PRINT,  8'h00, 8'h2a, 1'b0, 1'b0}, // empty line, separator only
    '{CMD_TYPE,   8'h1f, 8'h00, 1'b1, 1'b0}, // just below the printable range
    '{CMD_TYPE,   8'h7f, 8'h00, 1'b1, 1'b0}, // just above it
    '{CMD_TYPE,   8'h00, 8'hff, 1'b1, 1'b0},
    '{CMD_TYPE,   8'hff, 8'h00, 1'b1, 1'b0},
    '{CMD_TYPE,   8'h20, 8'h00, 1'b1, 1'b1}, // lowest printable
    '{CMD_TYPE,   8'h7e, 8'h00, 1'b1, 1'b1}, // highest printable
    '{CMD_TYPE,   8'h41, 8'h00, 1'b0, 1'b0},
    '{CMD_LEFT,   8'h00, 8'h00, 1'b0, 1'b0},
    '{CMD_LEFT,   8'h00, 8'h00, 1'b0, 1'b0},
    '{CMD_TYPE,   8'h5a, 8'h00, 1'b0, 1'b0}, // insert in the middle, shifts the tail
    '{CMD_PRINT,  8'h00, 8'h7c, 1'b0, 1'b0}, // separator inside the line
    '{CMD_HOME,   8'h00, 8'h00, 1'b0, 1'b0},
    '{CMD_ERASE,  8'h00, 8'h00, 1'b1, 1'b0}, // start of a non-empty line
    '{CMD_TYPE,   8'h30, 8'h00, 1'b0, 1'b0}, // insert at the front
    '{CMD_PRINT,  8'h00, 8'hff, 1'b0, 1'b0},
    '{CMD_END,    8'h00, 8'h00, 1'b0, 1'b0},
    '{CMD_ERASE,  8'h00, 8'h00, 1'b0, 1'b0}, // erase at the end, no shift
    '{CMD_RIGHT,  8'h00, 8'h00, 1'b1, 1'b1},
    '{CMD_UNUSED, 8'hff, 8'hff, 1'b1, 1'b1}, // unused code, does nothing
    '{CMD_PRINT,  8'h00, 8'h00, 1'b0, 1'b0}  // separator off, cursor at the end
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] command;
  logic [7:0] key_char;
  logic [7:0] cursor_mark;
  logic       out_valid;
  logic       out_stall;
  logic       success;
  logic       has_char;
  logic [7:0] out_char;
  logic       last;

  line_edit_buffer #(
    .CAPACITY(LEB_CAPACITY)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .key_char   (key_char),
    .cursor_mark(cursor_mark),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .success    (success),
    .has_char   (has_char),
    .out_char   (out_char),
    .last       (last)
  );

  // shadow copy of the line and cursor
  logic [7:0] line_text [LEB_CAPACITY];
  int         line_len;
  int         cursor_at;

  // results of the last modeled command, and everything still to arrive
  edit_out_t  step_out [$];
  edit_out_t  pending_out [$];

  int  errors;
  int  cmds_sent;
  int  results_seen;
  int  longest_line;
  int  full_rejects;
  int  hang_count;
  int  stall_left;
  bit  quiet;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // append one expected result of the command being modeled
  function automatic void add_step(input logic ok, input logic has, input logic [7:0] ch,
                                   input logic fin);
    edit_out_t item;
    item = '{ok, has, ch, fin};
    step_out = {step_out, item};
  endfunction

  // expected results of one command; updates the shadow line and cursor
  function automatic void edit_model(input logic [2:0] c, input logic [7:0] k,
                                     input logic [7:0] m);
    logic ok;
    int   total;
    int   n;
    step_out.delete();
    ok = 1'b1;
    case (c)
      CMD_TYPE: begin
        if (k < CHAR_LOW || k > CHAR_HIGH) begin
          ok = 1'b0;
        end else if (line_len >= LEB_CAPACITY) begin
          // printable key but no room left
          ok = 1'b0;
          full_rejects++;
        end else begin
          for (int i = line_len; i > cursor_at; i--) line_text[i] = line_text[i-1];
          line_text[cursor_at] = k;
          line_len++;
          cursor_at++;
          if (line_len > longest_line) longest_line = line_len;
        end
      end
      CMD_ERASE: begin
        if (cursor_at == 0) begin
          ok = 1'b0;
        end else begin
          for (int i = cursor_at - 1; i + 1 < line_len; i++) line_text[i] = line_text[i+1];
          line_len--;
          cursor_at--;
        end
      end
      CMD_HOME:  cursor_at = 0;
      CMD_END:   cursor_at = line_len;
      CMD_LEFT:  if (cursor_at > 0) cursor_at--;
      CMD_RIGHT: if (cursor_at < line_len) cursor_at++;
      CMD_PRINT: begin
        total = line_len + ((m != 8'h00) ? 1 : 0);
        n = 0;
        if (total == 0) begin
          add_step(1'b1, 1'b0, 8'h00, 1'b1);
        end else begin
          for (int i = 0; i <= line_len; i++) begin
            if (i == cursor_at && m != 8'h00) begin
              n++;
              add_step(1'b1, 1'b1, m, n == total);
            end
            if (i < line_len) begin
              n++;
              add_step(1'b1, 1'b1, line_text[i], n == total);
            end
          end
        end
      end
      default: ;
    endcase
    // every command but print gives one plain status result
    if (c != CMD_PRINT) add_step(ok, 1'b0, 8'h00, 1'b1);
  endfunction

  // drive one command, wait for its transfer, then queue what it should produce
  task automatic send_cmd(input logic [2:0] c, input logic [7:0] k, input logic [7:0] m,
                          input logic typed, input logic typed_ok);
    int        gap;
    edit_out_t typed_item;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= c;
    key_char    <= k;
    cursor_mark <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer happened at this edge
    edit_model(c, k, m);
    if (typed) begin
      typed_item = '{typed_ok, 1'b0, 8'h00, 1'b1};
      pending_out = {pending_out, typed_item};
    end else begin
      pending_out = {pending_out, step_out};
    end
    cmds_sent++;
  endtask

  // one random command, weighted toward typing so the line grows and shifts get long
  task automatic send_random();
    int         pick;
    logic [2:0] c;
    logic [7:0] k;
    logic [7:0] m;
    pick = $urandom_range(0, 99);
    k = 8'($urandom_range(0, 255));
    m = 8'($urandom_range(0, 255));
    if (pick < 35) begin
      c = CMD_TYPE;
      k = 8'($urandom_range(32, 126));
    end else if (pick < 45) begin
      c = CMD_TYPE;  // any byte, mostly unprintable
    end else if (pick < 60) begin
      c = CMD_ERASE;
    end else if (pick < 65) begin
      c = CMD_HOME;
    end else if (pick < 70) begin
      c = CMD_END;
    end else if (pick < 78) begin
      c = CMD_LEFT;
    end else if (pick < 86) begin
      c = CMD_RIGHT;
    end else if (pick < 97) begin
      c = CMD_PRINT;
      if ($urandom_range(0, 3) == 0) m = 8'h00;
    end else begin
      c = CMD_UNUSED;
    end
    send_cmd(c, k, m, 1'b0, 1'b0);
  endtask

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  // result checker: every output transfer is matched against the oldest expectation
  always @(posedge clk) begin
    edit_out_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, got success %0b char %0h last %0b",
                 $time, success, out_char, last);
        errors++;
      end else begin
        exp_item = pending_out.pop_front();
        check_field("success", 8'(exp_item.success), 8'(success));
        check_field("has_char", 8'(exp_item.has_char), 8'(has_char));
        check_field("out_char", exp_item.out_char, out_char);
        check_field("last", 8'(exp_item.last), 8'(last));
      end
    end
  end

  // output stall in random bursts of stalled or free runs
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(1, 8) - 1;
    end
  end

  // watchdog: any transfer on either side restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = CMD_HOME;
    key_char     = 8'h00;
    cursor_mark  = 8'h00;
    out_stall    = 1'b0;
    stall_left   = 0;
    quiet        = 1'b0;
    errors       = 0;
    cmds_sent    = 0;
    results_seen = 0;
    longest_line = 0;
    full_rejects = 0;
    hang_count   = 0;
    line_len     = 0;
    cursor_at    = 0;
    foreach (line_text[i]) line_text[i] = 8'h00;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_cmd(DIR_TABLE[r].cmd, DIR_TABLE[r].key, DIR_TABLE[r].mark,
               DIR_TABLE[r].typed, DIR_TABLE[r].ok);
    end

    // fill the line to capacity with random text, sometimes stepping left so
    // inserts land in the middle and shift long tails
    while (line_len < LEB_CAPACITY) begin
      if ($urandom_range(0, 9) == 0) begin
        send_cmd(CMD_LEFT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'b0, 1'b0);
      end else begin
        send_cmd(CMD_TYPE, 8'($urandom_range(32, 126)), 8'($urandom_range(0, 255)),
                 1'b0, 1'b0);
      end
    end
    // full line: printable keys must bounce
    repeat (3) send_cmd(CMD_TYPE, 8'($urandom_range(32, 126)), 8'h00, 1'b0, 1'b0);
    // longest print, with and without the separator
    send_cmd(CMD_PRINT, 8'h00, 8'($urandom_range(1, 255)), 1'b0, 1'b0);
    send_cmd(CMD_PRINT, 8'($urandom_range(0, 255)), 8'h00, 1'b0, 1'b0);

    // random edits from a full line, with idling on both sides
    repeat (20) send_random();

    // last stretch with no idling anywhere
    quiet = 1'b1;
    repeat (10) send_random();
    send_cmd(CMD_PRINT, 8'h00, 8'h7c, 1'b0, 1'b0);

    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands, %0d results checked", cmds_sent, results_seen);
    $display("longest line %0d chars, %0d types refused on a full line",
             longest_line, full_rejects);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/leb_pkg.sv
rtl/leb_text_ram.sv
rtl/line_edit_buffer.sv
sim/line_edit_buffer_test.sv
